FILE: sv/sorted_table_binary_search_top_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the sorted table search block
// Concurrent checks that compile away when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef SORTED_TABLE_BINARY_SEARCH_TOP_MACROS_SVH
`define SORTED_TABLE_BINARY_SEARCH_TOP_MACROS_SVH

`ifndef SYNTH
// same-cycle implication, checked out of reset
`define STBS_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("stbs check failed");
// next-cycle implication, checked out of reset
`define STBS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("stbs check failed");
`else
`define STBS_ASSERT_NOW(label, clk, rst, ante, cons)
`define STBS_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

FILE: sv/stbs_pkg.sv
// ----------------------------------------------------------------------------
// stbs_pkg
// Shared widths, codes and controller/datapath structs for the table search.
// ----------------------------------------------------------------------------
package stbs_pkg;

   // field widths
   localparam int VALUE_W     = 32;
   localparam int ENTRY_POS_W = 10;
   localparam int COUNT_W     = 11;
   localparam int POS_W       = 11;
   localparam int PROBE_W     = 4;
   localparam int MODE_W      = 2;
   localparam int CSR_IDX_W   = 1;
   localparam int CSR_DATA_W  = 11;

   localparam logic [PROBE_W-1:0] PROBE_MAX = 4'd15;

   // item actions
   localparam logic ACTION_WRITE  = 1'b0;
   localparam logic ACTION_SEARCH = 1'b1;

   // search modes; the spare code behaves as lower bound
   localparam logic [MODE_W-1:0] MODE_CLOSED = 2'd0;
   localparam logic [MODE_W-1:0] MODE_HALF   = 2'd1;
   localparam logic [MODE_W-1:0] MODE_LOWER  = 2'd2;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_SEARCH_MODE = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ENTRY_COUNT = 1'd1;

   // controller to datapath
   typedef struct packed {
      logic write;    // store the accepted word in the table
      logic start;    // load bounds for a new search
      logic probe;    // table word for the current midpoint is on the RAM output
      logic capture;  // load the result register
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic empty;    // no entries in use
      logic done;     // current probe ends the search
   } sts_type;

endpackage

FILE: sv/stbs_ifs.sv
// ----------------------------------------------------------------------------
// Channel interfaces
// Valid/ready channels for request words and response words.
// ----------------------------------------------------------------------------
interface stbs_req_if;
   logic                                   valid;
   logic                                   ready;
   logic                                   action;
   logic        [stbs_pkg::ENTRY_POS_W-1:0] entry_position;
   logic signed [stbs_pkg::VALUE_W-1:0]     entry_value;
   logic signed [stbs_pkg::VALUE_W-1:0]     search_key;

   modport source (output valid, action, entry_position, entry_value, search_key,
                   input ready);
   modport sink   (input valid, action, entry_position, entry_value, search_key,
                   output ready);
endinterface

interface stbs_rsp_if;
   logic                               valid;
   logic                               ready;
   logic                               hit;
   logic [stbs_pkg::POS_W-1:0]         position;
   logic [stbs_pkg::PROBE_W-1:0]       probe_count;

   modport source (output valid, hit, position, probe_count, input ready);
   modport sink   (input valid, hit, position, probe_count, output ready);
endinterface

FILE: sv/stbs_ram.sv
// ----------------------------------------------------------------------------
// stbs_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module stbs_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                                        clock,
   input  logic                                        wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                            wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                            rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: sv/stbs_dp.sv
// ----------------------------------------------------------------------------
// stbs_dp
// Search datapath: config registers, table RAM, bounds, compare and result.
// ----------------------------------------------------------------------------
`include "sorted_table_binary_search_top_macros.svh"

module stbs_dp #(
   parameter int TABLE_DEPTH = 1024
) (
   input  logic                                    clock,
   input  logic                                    reset,
   // register writes
   input  logic                                    csr_we,
   input  logic [stbs_pkg::CSR_IDX_W-1:0]          csr_index,
   input  logic [stbs_pkg::CSR_DATA_W-1:0]         csr_wdata,
   // request word
   input  logic [stbs_pkg::ENTRY_POS_W-1:0]        entry_position,
   input  logic signed [stbs_pkg::VALUE_W-1:0]     entry_value,
   input  logic signed [stbs_pkg::VALUE_W-1:0]     search_key,
   // control
   input  stbs_pkg::cmd_type                       cmd,
   output stbs_pkg::sts_type                       sts,
   // response word
   output logic                                    hit,
   output logic [stbs_pkg::POS_W-1:0]              position,
   output logic [stbs_pkg::PROBE_W-1:0]            probe_count
);

   localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int BW = $clog2(TABLE_DEPTH + 1);
   localparam int CW = (BW > stbs_pkg::COUNT_W) ? BW : stbs_pkg::COUNT_W;
   localparam int PW = (BW > stbs_pkg::ENTRY_POS_W) ? BW : stbs_pkg::ENTRY_POS_W;

   // configuration
   logic [stbs_pkg::MODE_W-1:0]  mode_ff;
   logic [stbs_pkg::COUNT_W-1:0] count_ff;

   // search state
   logic [BW-1:0]                     lo_ff, lo_in;
   logic [BW-1:0]                     hi_ff, hi_in;
   logic [BW-1:0]                     mid_ff, mid_in;
   logic signed [stbs_pkg::VALUE_W-1:0] key_ff;
   logic [stbs_pkg::PROBE_W-1:0]      probes_ff, probes_in;

   // result register
   logic                              hit_ff, hit_in;
   logic [stbs_pkg::POS_W-1:0]        pos_ff, pos_in;
   logic [stbs_pkg::PROBE_W-1:0]      cnt_ff, cnt_in;

   logic                              exact;
   logic                              closed;
   logic [CW-1:0]                     count_ext;
   logic [CW-1:0]                     n_wide;
   logic [BW-1:0]                     n_eff;
   logic [BW-1:0]                     mid0;
   logic [BW-1:0]                     next_lo, next_hi, next_mid;
   logic                              keep_going;
   logic                              found;
   logic                              less;
   logic [CW-1:0]                     pos_wide;
   logic [PW-1:0]                     wr_pos_ext;
   logic                              wr_en;
   logic [AW-1:0]                     rd_addr;
   logic [stbs_pkg::VALUE_W-1:0]      rd_data;

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= stbs_pkg::MODE_CLOSED;
         count_ff <= '0;
      end else if (csr_we) begin
         case (csr_index)
            stbs_pkg::CSR_SEARCH_MODE: mode_ff  <= csr_wdata[stbs_pkg::MODE_W-1:0];
            stbs_pkg::CSR_ENTRY_COUNT: count_ff <= csr_wdata[stbs_pkg::COUNT_W-1:0];
            default: ;
         endcase
      end
   end

   assign closed = (mode_ff == stbs_pkg::MODE_CLOSED);
   assign exact  = (mode_ff == stbs_pkg::MODE_CLOSED) || (mode_ff == stbs_pkg::MODE_HALF);

   // entries in use, clamped to the table depth
   assign count_ext = CW'(count_ff);
   assign n_wide    = (count_ext > CW'(TABLE_DEPTH)) ? CW'(TABLE_DEPTH) : count_ext;
   assign n_eff     = n_wide[BW-1:0];

   // closed interval [lo, hi-1] kept as half-open; its midpoint rounds one lower
   assign mid0 = (n_eff - BW'(closed)) >> 1;

   // one probe: compare the RAM word and narrow the bounds
   assign less       = ($signed(rd_data) < key_ff);
   assign found      = exact && (rd_data == key_ff);
   assign next_lo    = less ? (mid_ff + BW'(1)) : lo_ff;
   assign next_hi    = less ? hi_ff : mid_ff;
   assign keep_going = (next_lo < next_hi);
   assign next_mid   = next_lo + ((next_hi - next_lo - BW'(closed)) >> 1);

   assign sts.empty = (n_eff == '0);
   assign sts.done  = found || !keep_going;

   // bounds and probe counter
   always_comb begin
      lo_in     = lo_ff;
      hi_in     = hi_ff;
      mid_in    = mid_ff;
      probes_in = probes_ff;
      if (cmd.start) begin
         lo_in     = '0;
         hi_in     = n_eff;
         mid_in    = mid0;
         probes_in = '0;
      end else if (cmd.probe) begin
         lo_in     = next_lo;
         hi_in     = next_hi;
         mid_in    = next_mid;
         probes_in = (probes_ff == stbs_pkg::PROBE_MAX) ? probes_ff
                                                        : probes_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      lo_ff     <= lo_in;
      hi_ff     <= hi_in;
      mid_ff    <= mid_in;
      probes_ff <= probes_in;
      if (cmd.start) begin
         key_ff <= search_key;
      end
   end

   // result word: empty table gives all zeros
   assign pos_wide = found ? CW'(mid_ff) : CW'(next_lo);
   always_comb begin
      hit_in = 1'b0;
      pos_in = '0;
      cnt_in = '0;
      if (cmd.probe) begin
         cnt_in = (probes_ff == stbs_pkg::PROBE_MAX) ? probes_ff : probes_ff + 1'b1;
         if (exact) begin
            hit_in = found;
            pos_in = found ? pos_wide[stbs_pkg::POS_W-1:0] : '0;
         end else begin
            hit_in = (next_lo < n_eff);
            pos_in = pos_wide[stbs_pkg::POS_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         hit_ff <= hit_in;
         pos_ff <= pos_in;
         cnt_ff <= cnt_in;
      end
   end

   assign hit         = hit_ff;
   assign position    = pos_ff;
   assign probe_count = cnt_ff;

   // table RAM; writes past the depth are dropped
   assign wr_pos_ext = PW'(entry_position);
   assign wr_en      = cmd.write && (wr_pos_ext < PW'(TABLE_DEPTH));
   assign rd_addr    = cmd.start ? mid0[AW-1:0] : next_mid[AW-1:0];

   stbs_ram #(
      .WIDTH (stbs_pkg::VALUE_W),
      .DEPTH (TABLE_DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_pos_ext[AW-1:0]),
      .wr_data (entry_value),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // a probe always works on a non-empty interval
   `STBS_ASSERT_NOW(a_dp_interval, clock, reset, cmd.probe, lo_ff < hi_ff)

endmodule

FILE: sv/stbs_ctrl.sv
// ----------------------------------------------------------------------------
// stbs_ctrl
// Search sequencer and response valid flag.
// ----------------------------------------------------------------------------
`include "sorted_table_binary_search_top_macros.svh"

module stbs_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_action,
   output logic              req_ready,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output stbs_pkg::cmd_type cmd,
   input  stbs_pkg::sts_type sts
);

   typedef enum logic {
      ST_IDLE,
      ST_PROBE
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      accept;

   // take a word only when idle and the result slot is free at this edge
   assign req_ready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_ready);
   assign accept    = req_valid && req_ready;

   assign cmd.write   = accept && (req_action == stbs_pkg::ACTION_WRITE);
   assign cmd.start   = accept && (req_action == stbs_pkg::ACTION_SEARCH);
   assign cmd.probe   = (state_ff == ST_PROBE);
   assign cmd.capture = (cmd.start && sts.empty) || (cmd.probe && sts.done);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:  begin
            if (cmd.start && !sts.empty) begin
               state_in = ST_PROBE;
            end
         end
         ST_PROBE: begin
            if (sts.done) begin
               state_in = ST_IDLE;
            end
         end
         default:  state_in = ST_IDLE;
      endcase
   end

   assign rsp_valid_in = cmd.capture ? 1'b1 : (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   `STBS_ASSERT_NOW(a_ctrl_busy, clock, reset, state_ff == ST_PROBE, !req_ready)
   `STBS_ASSERT_NOW(a_ctrl_slot, clock, reset, cmd.capture, !rsp_valid_ff || rsp_ready)
   `STBS_ASSERT_NEXT(a_ctrl_show, clock, reset, cmd.capture, rsp_valid_ff)

endmodule

FILE: sv/sorted_table_binary_search_top.sv
// ----------------------------------------------------------------------------
// sorted_table_binary_search_top
// Sorted-table binary search: lower bound and two exact-match variants.
// ----------------------------------------------------------------------------
// A write word stores entry_value at entry_position when it is accepted and
// gives no response. A search word sets up the bounds and issues the first
// table read on acceptance, then makes at most log2(TABLE_DEPTH)+1 probes
// (11 at depth 1024); the response word is presented the cycle after the
// last probe. The probe rate is set by the loop from the table RAM's
// registered read port through the key compare back to the next read address.
// One search is in flight at a time; the next word is taken once the search
// has finished and the response slot is free. The table is not cleared by
// reset; only entries written before they are searched give defined answers.
// ----------------------------------------------------------------------------
module sorted_table_binary_search_top #(
   parameter int TABLE_DEPTH = 1024
) (
   input  logic                             clock,
   input  logic                             reset,
   stbs_req_if.sink                         req_bus,
   stbs_rsp_if.source                       rsp_bus,
   input  logic                             csr_we,
   input  logic [stbs_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [stbs_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   stbs_pkg::cmd_type cmd;
   stbs_pkg::sts_type sts;

   stbs_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_bus.valid),
      .req_action (req_bus.action),
      .req_ready  (req_bus.ready),
      .rsp_valid  (rsp_bus.valid),
      .rsp_ready  (rsp_bus.ready),
      .cmd        (cmd),
      .sts        (sts)
   );

   stbs_dp #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .entry_position (req_bus.entry_position),
      .entry_value    (req_bus.entry_value),
      .search_key     (req_bus.search_key),
      .cmd            (cmd),
      .sts            (sts),
      .hit            (rsp_bus.hit),
      .position       (rsp_bus.position),
      .probe_count    (rsp_bus.probe_count)
   );

endmodule

FILE: verif/sorted_table_binary_search_top_test.sv
// ----------------------------------------------------------------------------
// Testbench for sorted_table_binary_search_top
// Loads table entries through the request channel and checks every search
// response against a bisection predictor kept in step with the table and the
// two registers. A short directed run covers the extremes and every mode.
// Random phases follow, mostly sorted tables with keys drawn from the table,
// with random idling on both channels and a long response hold-off.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module sorted_table_binary_search_top_test;

   localparam int DEPTH           = 1024;
   localparam int SETTLE_CYCLES   = 20;
   localparam int WATCHDOG_LIMIT  = 4000;
   localparam int PRESSURE_CYCLES = 400;
   localparam int RANDOM_WORDS    = 2000;

   // decodes as lower bound
   localparam logic [stbs_pkg::MODE_W-1:0]         MODE_SPARE = 2'd3;
   localparam logic signed [stbs_pkg::VALUE_W-1:0] VALUE_MIN  = 32'sh8000_0000;
   localparam logic signed [stbs_pkg::VALUE_W-1:0] VALUE_MAX  = 32'sh7fff_ffff;

   typedef struct packed {
      logic                         hit;
      logic [stbs_pkg::POS_W-1:0]   position;
      logic [stbs_pkg::PROBE_W-1:0] probe_count;
   } search_result_type;

   // Table copy, register copy and the queue of answers still owed
   class search_scoreboard;
      logic signed [stbs_pkg::VALUE_W-1:0] entries [DEPTH];
      logic [stbs_pkg::MODE_W-1:0]         mode;
      logic [stbs_pkg::COUNT_W-1:0]        count;
      search_result_type                   answers_due [$];
      int                                  errors;

      function new();
         mode   = stbs_pkg::MODE_CLOSED;
         count  = '0;
         errors = 0;
      endfunction

      function void note_register(logic [stbs_pkg::CSR_IDX_W-1:0] index,
                                  logic [stbs_pkg::CSR_DATA_W-1:0] data);
         if (index == stbs_pkg::CSR_SEARCH_MODE) begin
            mode = data[stbs_pkg::MODE_W-1:0];
         end else begin
            count = data[stbs_pkg::COUNT_W-1:0];
         end
      endfunction

      // counts above the table depth are clipped
      function int in_use();
         return (count > DEPTH) ? DEPTH : int'(count);
      endfunction

      function search_result_type bisect(logic signed [stbs_pkg::VALUE_W-1:0] key);
         int                n, lo, hi, mid, probes;
         search_result_type res;
         n      = in_use();
         probes = 0;
         res    = '0;
         if (mode == stbs_pkg::MODE_CLOSED) begin
            lo = 0;
            hi = n - 1;
            while (lo <= hi) begin
               probes++;
               mid = lo + (hi - lo) / 2;
               if (entries[mid] == key) begin
                  res.hit      = 1'b1;
                  res.position = stbs_pkg::POS_W'(mid);
                  break;
               end
               if (entries[mid] < key) lo = mid + 1;
               else hi = mid - 1;
            end
         end else if (mode == stbs_pkg::MODE_HALF) begin
            lo = 0;
            hi = n;
            while (lo < hi) begin
               probes++;
               mid = lo + (hi - lo) / 2;
               if (entries[mid] == key) begin
                  res.hit      = 1'b1;
                  res.position = stbs_pkg::POS_W'(mid);
                  break;
               end
               if (entries[mid] < key) lo = mid + 1;
               else hi = mid;
            end
         end else begin
            // lower bound, also taken by the spare mode code
            lo = 0;
            hi = n;
            while (lo < hi) begin
               probes++;
               mid = lo + (hi - lo) / 2;
               if (entries[mid] < key) lo = mid + 1;
               else hi = mid;
            end
            res.position = stbs_pkg::POS_W'(lo);
            res.hit      = (lo < n);
         end
         res.probe_count = (probes > stbs_pkg::PROBE_MAX) ? stbs_pkg::PROBE_MAX
                                                          : stbs_pkg::PROBE_W'(probes);
         return res;
      endfunction

      function void note_request(logic action, logic [stbs_pkg::ENTRY_POS_W-1:0] pos,
                                 logic signed [stbs_pkg::VALUE_W-1:0] value,
                                 logic signed [stbs_pkg::VALUE_W-1:0] key);
         if (action == stbs_pkg::ACTION_WRITE) begin
            entries[pos] = value;
         end else begin
            answers_due.push_back(bisect(key));
         end
      endfunction

      function int pending();
         return answers_due.size();
      endfunction

      function void compare(string field, logic [15:0] want, logic [15:0] got);
         if (want !== got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
            errors++;
         end
      endfunction

      function void check_response(search_result_type got);
         search_result_type want;
         if (answers_due.size() == 0) begin
            $display("%0t: unexpected response word, hit %0d position %0d probes %0d",
                     $time, got.hit, got.position, got.probe_count);
            errors++;
            return;
         end
         want = answers_due.pop_front();
         compare("hit", 16'(want.hit), 16'(got.hit));
         compare("position", 16'(want.position), 16'(got.position));
         compare("probe_count", 16'(want.probe_count), 16'(got.probe_count));
      endfunction
   endclass

   logic                            clock;
   logic                            reset;
   logic                            csr_we;
   logic [stbs_pkg::CSR_IDX_W-1:0]  csr_index;
   logic [stbs_pkg::CSR_DATA_W-1:0] csr_wdata;

   stbs_req_if req_bus ();
   stbs_rsp_if rsp_bus ();

   search_scoreboard sb = new();
   int words_sent    = 0;
   int sender_calm   = 0;
   int receiver_calm = 0;
   int idle_cycles   = 0;

   sorted_table_binary_search_top u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .rsp_bus   (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial clock = 1'b0;
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // mostly short gaps, a few long ones, and now and then a run with none
   function automatic int pick_gap(inout int calm);
      int r;
      if (calm > 0) begin
         calm--;
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r < 2) begin
         calm = $urandom_range(20, 80);
         return 0;
      end
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // keys: mostly table entries or their neighbours, some extremes, some noise
   function automatic logic signed [stbs_pkg::VALUE_W-1:0] pick_key();
      int                                  n, r;
      logic signed [stbs_pkg::VALUE_W-1:0] entry;
      n = sb.in_use();
      r = $urandom_range(0, 9);
      if (n > 0 && r < 7) begin
         entry = sb.entries[$urandom_range(0, n - 1)];
         if (r == 5) return entry + 1;
         if (r == 6) return entry - 1;
         return entry;
      end
      if (r == 7) return ($urandom_range(0, 1) == 1) ? VALUE_MAX : VALUE_MIN;
      return $urandom;
   endfunction

   // offer one request word after a random gap and wait for it to be taken
   task automatic send_word(logic action, logic [stbs_pkg::ENTRY_POS_W-1:0] pos,
                            logic signed [stbs_pkg::VALUE_W-1:0] value,
                            logic signed [stbs_pkg::VALUE_W-1:0] key);
      int gap;
      gap = pick_gap(sender_calm);
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid          <= 1'b1;
      req_bus.action         <= action;
      req_bus.entry_position <= pos;
      req_bus.entry_value    <= value;
      req_bus.search_key     <= key;
      do @(posedge clock); while (!req_bus.ready);
      sb.note_request(action, pos, value, key);
      words_sent++;
   endtask

   // drain: all responses in, then room for a trailing write word to finish
   task automatic quiesce();
      req_bus.valid <= 1'b0;
      do @(posedge clock); while (sb.pending() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_registers(logic [stbs_pkg::MODE_W-1:0] mode,
                                logic [stbs_pkg::COUNT_W-1:0] count);
      csr_we    <= 1'b1;
      csr_index <= stbs_pkg::CSR_SEARCH_MODE;
      csr_wdata <= stbs_pkg::CSR_DATA_W'(mode);
      @(posedge clock);
      sb.note_register(stbs_pkg::CSR_SEARCH_MODE, stbs_pkg::CSR_DATA_W'(mode));
      csr_index <= stbs_pkg::CSR_ENTRY_COUNT;
      csr_wdata <= stbs_pkg::CSR_DATA_W'(count);
      @(posedge clock);
      sb.note_register(stbs_pkg::CSR_ENTRY_COUNT, stbs_pkg::CSR_DATA_W'(count));
      csr_we <= 1'b0;
   endtask

   // ascending fill of positions 0..m-1; small steps give runs of duplicates
   task automatic fill_sorted(int m);
      longint v, step_max;
      int     i;
      case ($urandom_range(0, 3))
         0: step_max = 0;
         1: step_max = 3;
         2: step_max = 1000;
         default: step_max = 64'd1 << 22;
      endcase
      if (step_max > 1000 || $urandom_range(0, 7) == 0) begin
         v = longint'(VALUE_MIN) + $urandom_range(0, 1000);
      end else begin
         v = longint'($signed($urandom));
      end
      for (i = 0; i < m; i++) begin
         if (i == m - 1 && $urandom_range(0, 7) == 0) v = VALUE_MAX;
         send_word(stbs_pkg::ACTION_WRITE, stbs_pkg::ENTRY_POS_W'(i),
                   stbs_pkg::VALUE_W'(v), $urandom);
         v = v + $urandom_range(0, int'(step_max));
         if (v > VALUE_MAX) v = VALUE_MAX;
      end
   endtask

   // response side: random back-pressure plus a long hold at 60 responses, then every 400
   initial begin
      int hold, seen, pressure_at;
      hold        = 0;
      seen        = 0;
      pressure_at = 60;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_bus.valid && rsp_bus.ready) begin
            sb.check_response(search_result_type'({rsp_bus.hit, rsp_bus.position,
                                                   rsp_bus.probe_count}));
            seen++;
         end
         if (seen >= pressure_at) begin
            hold        = PRESSURE_CYCLES;
            pressure_at = pressure_at + 400;
         end else if (hold > 0) begin
            hold--;
         end else begin
            hold = pick_gap(receiver_calm);
         end
         rsp_bus.ready <= (hold == 0) && !reset;
      end
   end

   // watchdog on cycles with no word moving on either channel
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: timeout, no word moved for %0d cycles", $time, WATCHDOG_LIMIT);
         $display("FAILED: results differ");
         $finish;
      end
   end

   initial begin
      logic signed [stbs_pkg::VALUE_W-1:0] seed_values [8];
      logic [stbs_pkg::MODE_W-1:0]         mode;
      int                                  base, n, i, r;

      seed_values = '{VALUE_MIN, -32'sd5, 32'sd3, 32'sd3, 32'sd3, 32'sd10, 32'sd100, VALUE_MAX};

      reset                  <= 1'b1;
      csr_we                 <= 1'b0;
      csr_index              <= stbs_pkg::CSR_SEARCH_MODE;
      csr_wdata              <= '0;
      req_bus.valid          <= 1'b0;
      req_bus.action         <= stbs_pkg::ACTION_WRITE;
      req_bus.entry_position <= '0;
      req_bus.entry_value    <= '0;
      req_bus.search_key     <= '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // empty table out of reset: closed-interval miss with no probes
      send_word(stbs_pkg::ACTION_SEARCH, '0, '0, 32'sd5);

      // small sorted table with both extremes and a run of duplicates
      for (i = 0; i < 8; i++) begin
         send_word(stbs_pkg::ACTION_WRITE, stbs_pkg::ENTRY_POS_W'(i), seed_values[i],
                   $urandom);
      end

      quiesce();
      set_registers(stbs_pkg::MODE_CLOSED, 11'd8);
      send_word(stbs_pkg::ACTION_SEARCH, '0, '0, 32'sd3);
      send_word(stbs_pkg::ACTION_SEARCH, '0, '0, VALUE_MIN);
      send_word(stbs_pkg::ACTION_SEARCH, '0, '0, VALUE_MAX);
      send_word(stbs_pkg::ACTION_SEARCH, '0, '0, 32'sd4);

      // half-open lands on a different duplicate
      quiesce();
      set_registers(stbs_pkg::MODE_HALF, 11'd8);
      send_word(stbs_pkg::ACTION_SEARCH, '0, '0, 32'sd3);
      send_word(stbs_pkg::ACTION_SEARCH, '0, '0, 32'sd0);

      quiesce();
      set_registers(stbs_pkg::MODE_LOWER, 11'd8);
      send_word(stbs_pkg::ACTION_SEARCH, '0, '0, 32'sd3);
      send_word(stbs_pkg::ACTION_SEARCH, '0, '0, VALUE_MAX);
      send_word(stbs_pkg::ACTION_SEARCH, '0, '0, VALUE_MIN);

      quiesce();
      set_registers(MODE_SPARE, 11'd8);
      send_word(stbs_pkg::ACTION_SEARCH, '0, '0, 32'sd11);

      // empty table in lower bound and half-open
      quiesce();
      set_registers(stbs_pkg::MODE_LOWER, 11'd0);
      send_word(stbs_pkg::ACTION_SEARCH, '0, '0, 32'sd7);
      quiesce();
      set_registers(stbs_pkg::MODE_HALF, 11'd0);
      send_word(stbs_pkg::ACTION_SEARCH, '0, '0, 32'sd7);

      // full table, so that every later count reads only written entries
      base = words_sent;
      quiesce();
      set_registers(stbs_pkg::MODE_LOWER, 11'(DEPTH));
      fill_sorted(DEPTH);
      for (i = 0; i < 4; i++) begin
         quiesce();
         case (i)
            0: set_registers(stbs_pkg::MODE_CLOSED, 11'(DEPTH));
            1: set_registers(stbs_pkg::MODE_HALF, 11'd1025);
            2: set_registers(stbs_pkg::MODE_LOWER, 11'(DEPTH));
            default: set_registers(MODE_SPARE, 11'd2047);
         endcase
         repeat (25) begin
            send_word(stbs_pkg::ACTION_SEARCH, stbs_pkg::ENTRY_POS_W'($urandom),
                      $urandom, pick_key());
         end
      end

      // random phases, mostly small counts with a fresh sorted prefix
      while (words_sent - base < RANDOM_WORDS) begin
         r = $urandom_range(0, 19);
         if (r == 0) n = $urandom_range(1025, 2047);
         else if (r == 1) n = DEPTH;
         else if (r <= 3) n = $urandom_range(65, DEPTH);
         else n = $urandom_range(0, 64);
         case ($urandom_range(0, 9))
            0: mode = MODE_SPARE;
            1, 2, 3: mode = stbs_pkg::MODE_CLOSED;
            4, 5, 6: mode = stbs_pkg::MODE_HALF;
            default: mode = stbs_pkg::MODE_LOWER;
         endcase
         quiesce();
         set_registers(mode, stbs_pkg::COUNT_W'(n));
         if (n <= 64 && $urandom_range(0, 9) < 7) fill_sorted(n);
         repeat ($urandom_range(10, 30)) begin
            // stray write that may break the ordering
            if ($urandom_range(0, 9) == 0) begin
               send_word(stbs_pkg::ACTION_WRITE, stbs_pkg::ENTRY_POS_W'($urandom),
                         $urandom, $urandom);
            end
            send_word(stbs_pkg::ACTION_SEARCH, stbs_pkg::ENTRY_POS_W'($urandom),
                      $urandom, pick_key());
         end
      end

      quiesce();
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule
